@@ hdl/bitmap_slot_allocator_defines.svh @@
// Assertion macros used by the checker file.
`ifndef BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_DEFINES_SVH

// Clocked property, off while reset is asserted.
`define BSA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a clock edge.
`define BSA_NEVER(label, cond, msg) \
    `BSA_ASSERT(label, !(cond), msg)

`endif

@@ hdl/bsa_pkg.sv @@
package bsa_pkg;

    localparam int MAP_BYTES = 32;
    localparam int BYTE_W    = $clog2(MAP_BYTES);
    localparam int HINT_W    = $clog2(MAP_BYTES + 1);
    localparam int SIZE_W    = 6;
    localparam int INDEX_W   = 8;
    localparam int LIMIT_W   = HINT_W + 3;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [0:0]        REG_SIZE_BYTES = 1'b0;
    localparam logic [SIZE_W-1:0] SIZE_RESET     = SIZE_W'(32);
    localparam logic [7:0]        BYTE_FULL      = 8'hff;

    typedef enum logic [1:0] {
        FUNC_SET   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_FIND  = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        func_t              func;
        logic [INDEX_W-1:0] bit_index;
    } in_item_t;

    typedef struct packed {
        logic               old_bit;
        logic [INDEX_W-1:0] found_index;
        status_t            status;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic advance;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

@@ hdl/bsa_regs.sv @@
module bsa_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bsa_pkg::ADDR_W-1:0]   paddr,
    input  logic [bsa_pkg::DATA_W-1:0]   pwdata,
    output logic [bsa_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output logic [bsa_pkg::SIZE_W-1:0]   size_bytes
);
    import bsa_pkg::*;

    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] size_next;
    logic              sel_size;

    // word select; byte offset bits are don't-care
    assign sel_size = (paddr[ADDR_W-1] == REG_SIZE_BYTES);

    always_comb
    begin
        size_next = size_reg;
        if (psel && penable && pwrite && sel_size)
        begin
            size_next = pwdata[SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else
        begin
            size_reg <= size_next;
        end
    end

    assign prdata     = sel_size ? DATA_W'(size_reg) : '0;
    assign pready     = 1'b1;
    assign size_bytes = size_reg;

endmodule

@@ hdl/bsa_ctrl.sv @@
module bsa_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  bsa_pkg::dp_stat_t stat,
    output logic              in_stall,
    output bsa_pkg::dp_cmd_t  cmd
);
    import bsa_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // find walks one byte per cycle until a hit or the limit
                cmd.advance = !stat.scan_done;
                cmd.commit  = stat.scan_done && stat.out_free;
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

@@ hdl/bsa_dpath.sv @@
module bsa_dpath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  bsa_pkg::in_item_t           in_data,
    input  logic [bsa_pkg::SIZE_W-1:0]  size_bytes,
    input  bsa_pkg::dp_cmd_t            cmd,
    input  logic                        out_stall,
    output bsa_pkg::dp_stat_t           stat,
    output logic                        out_valid,
    output bsa_pkg::out_item_t          out_data
);
    import bsa_pkg::*;

    logic [7:0]         mark_reg [MAP_BYTES];
    logic [HINT_W-1:0]  hint_reg;
    logic [HINT_W-1:0]  hint_next;
    func_t              func_reg;
    logic [INDEX_W-1:0] bit_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    out_item_t          out_data_reg;

    logic [HINT_W-1:0]  limit;
    logic [LIMIT_W-1:0] limit_bits;
    logic               in_range;
    logic [BYTE_W-1:0]  tgt_byte;
    logic [2:0]         tgt_pos;
    logic [BYTE_W-1:0]  rd_addr;
    logic [7:0]         rd_byte;
    logic               hint_ok;
    logic               byte_full;
    logic [2:0]         free_pos;
    logic               wr_en;
    logic [7:0]         wr_data;
    out_item_t          res;

    assign limit = (size_bytes > SIZE_W'(MAP_BYTES)) ? HINT_W'(MAP_BYTES)
                                                      : HINT_W'(size_bytes);
    assign limit_bits = {limit, 3'b000};
    assign in_range   = (LIMIT_W'(bit_reg) < limit_bits);
    assign tgt_byte   = BYTE_W'(bit_reg >> 3);
    assign tgt_pos    = bit_reg[2:0];
    assign rd_addr    = (func_reg == FUNC_FIND) ? hint_reg[BYTE_W-1:0] : tgt_byte;
    assign rd_byte    = mark_reg[rd_addr];
    assign hint_ok    = (hint_reg < limit);
    assign byte_full  = (rd_byte == BYTE_FULL);

    // lowest clear bit of the byte under the hint
    always_comb
    begin
        free_pos = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (!rd_byte[i])
            begin
                free_pos = 3'(i);
            end
        end
    end

    assign stat.scan_done = (func_reg != FUNC_FIND) || !hint_ok || !byte_full;
    assign stat.out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        res       = '0;
        wr_en     = 1'b0;
        wr_data   = rd_byte;
        hint_next = hint_reg;
        if (func_reg == FUNC_FIND)
        begin
            if (hint_ok && !byte_full)
            begin
                res.found_index = INDEX_W'({hint_reg[BYTE_W-1:0], free_pos});
                res.status      = STATUS_OK;
                wr_en           = 1'b1;
                wr_data         = rd_byte | (8'h01 << free_pos);
            end
            else
            begin
                res.status = STATUS_FULL;
            end
        end
        else if (!in_range)
        begin
            res.status = STATUS_RANGE;
        end
        else
        begin
            res.old_bit = rd_byte[tgt_pos];
            res.status  = STATUS_OK;
            if (func_reg == FUNC_SET)
            begin
                wr_en   = 1'b1;
                wr_data = rd_byte | (8'h01 << tgt_pos);
            end
            else if (func_reg == FUNC_CLEAR)
            begin
                wr_en   = 1'b1;
                wr_data = rd_byte & ~(8'h01 << tgt_pos);
                if (hint_reg > HINT_W'(tgt_byte))
                begin
                    hint_next = HINT_W'(tgt_byte);
                end
            end
        end
        if (cmd.advance)
        begin
            hint_next = hint_reg + HINT_W'(1);
        end
        else if (!cmd.commit)
        begin
            hint_next = hint_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hint_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAP_BYTES; i++)
            begin
                mark_reg[i] <= '0;
            end
        end
        else
        begin
            hint_reg      <= hint_next;
            out_valid_reg <= out_valid_next;
            if (cmd.commit && wr_en)
            begin
                mark_reg[rd_addr] <= wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= in_data.func;
            bit_reg  <= in_data.bit_index;
        end
        if (cmd.commit)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hdl/bitmap_slot_allocator.sv @@
// Set, clear and read go from the accepting edge through the EXEC state into the output register;
// find first walks the full bytes from the search hint, and a stalled output holds the commit.
// Only one transaction is in work at a time: in_stall holds new input until the result commits.
// Reset (rst_n, async, active low): all marks clear, hint 0, size_bytes 32.
module bitmap_slot_allocator
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bsa_pkg::ADDR_W-1:0]   paddr,
    input  logic [bsa_pkg::DATA_W-1:0]   pwdata,
    output logic [bsa_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  bsa_pkg::in_item_t            in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output bsa_pkg::out_item_t           out_data
);
    import bsa_pkg::*;

    logic [SIZE_W-1:0] size_bytes;
    dp_cmd_t           cmd;
    dp_stat_t          stat;

    bsa_regs u_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .size_bytes (size_bytes)
    );

    bsa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    bsa_dpath u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_data    (in_data),
        .size_bytes (size_bytes),
        .cmd        (cmd),
        .out_stall  (out_stall),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_data   (out_data)
    );

endmodule

@@ hdl/bsa_checker.sv @@
`include "bitmap_slot_allocator_defines.svh"

module bsa_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  bsa_pkg::out_item_t           out_data
);
    import bsa_pkg::*;

    `BSA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "output dropped while stalled")
    `BSA_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_data), "stalled output changed")
    `BSA_ASSERT(a_one_in_flight, in_valid && !in_stall |=> in_stall, "second transaction taken while busy")
    `BSA_ASSERT(a_result_after_accept, $rose(out_valid) |-> $past(in_stall), "result without a transaction in work")
    `BSA_NEVER(a_fail_fields, out_valid && out_data.status != STATUS_OK && (out_data.found_index != '0 || out_data.old_bit), "failed transaction carries data")

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (.*);
